// ----- hdl/pmm_pkg.sv -----
`default_nettype none
// ============================================================================
// pmm_pkg
// Shared sizes, request and status codes, and the table write bundle of the
// table-driven Mealy machine engine.
// ============================================================================
package pmm_pkg;

    localparam int MAX_STATES    = 64;
    localparam int MAX_SYMBOLS   = 32;
    localparam int MAX_OUT_CHARS = 15;

    localparam int STATE_W   = $clog2(MAX_STATES);
    localparam int SYM_W     = $clog2(MAX_SYMBOLS);
    localparam int SYMCNT_W  = 6;
    localparam int ENTRY_W   = STATE_W + SYM_W;
    localparam int POS_W     = 4;
    localparam int LEN_W     = 4;
    localparam int CHAR_W    = 8;
    localparam int TRANS_W   = STATE_W + 1;
    localparam int ENTRIES   = MAX_STATES * MAX_SYMBOLS;
    localparam int CHAR_SLOTS = ENTRIES * (2 ** POS_W);

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD_SYMBOL = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_TRANS  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD_CHAR   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_START       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PROCESS     = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_CHAR      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_TRANS  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_HALTED    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ACK       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SYMBOLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE = 2'd2;

    typedef struct packed {
        logic               alpha_we;
        logic [SYM_W-1:0]   alpha_addr;
        logic [CHAR_W-1:0]  alpha_data;
        logic               trans_we;
        logic               len_we;
        logic               char_we;
        logic [ENTRY_W-1:0] entry;
        logic [TRANS_W-1:0] trans_data;
        logic [LEN_W-1:0]   len_data;
        logic [POS_W-1:0]   char_pos;
        logic [CHAR_W-1:0]  char_data;
    } pmm_wr_t;

endpackage
`default_nettype wire

// ----- hdl/pmm_tables.sv -----
`default_nettype none
// ============================================================================
// pmm_tables
// Alphabet, transition, output length and output character memories, each
// with one write port and one registered read port.
// ============================================================================
module pmm_tables (
    input  wire logic                          clk,
    input  wire pmm_pkg::pmm_wr_t              wr,
    input  wire logic [pmm_pkg::SYM_W-1:0]     alpha_raddr,
    input  wire logic [pmm_pkg::ENTRY_W-1:0]   entry_raddr,
    input  wire logic [pmm_pkg::ENTRY_W+pmm_pkg::POS_W-1:0] char_raddr,
    output logic      [pmm_pkg::CHAR_W-1:0]    alpha_rdata,
    output logic      [pmm_pkg::TRANS_W-1:0]   trans_rdata,
    output logic      [pmm_pkg::LEN_W-1:0]     len_rdata,
    output logic      [pmm_pkg::CHAR_W-1:0]    char_rdata
);
    import pmm_pkg::*;

    logic [CHAR_W-1:0]  alpha_mem [MAX_SYMBOLS];
    logic [TRANS_W-1:0] trans_mem [ENTRIES];
    logic [LEN_W-1:0]   len_mem   [ENTRIES];
    // Each entry owns a block of character slots addressed by {entry, position}.
    logic [CHAR_W-1:0]  char_mem  [CHAR_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.alpha_we)
        begin
            alpha_mem[wr.alpha_addr] <= wr.alpha_data;
        end
        alpha_rdata <= alpha_mem[alpha_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.trans_we)
        begin
            trans_mem[wr.entry] <= wr.trans_data;
        end
        trans_rdata <= trans_mem[entry_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.len_we)
        begin
            len_mem[wr.entry] <= wr.len_data;
        end
        len_rdata <= len_mem[entry_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.char_we)
        begin
            char_mem[{wr.entry, wr.char_pos}] <= wr.char_data;
        end
        char_rdata <= char_mem[char_raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/programmable_mealy_machine_core.sv -----
`default_nettype none
// ============================================================================
// programmable_mealy_machine_core
// Table-driven Mealy machine: loads fill the alphabet, transition and output
// tables; process items search the alphabet one slot per cycle and, if a
// transition exists, emit the old state's output string one character per cycle.
// ============================================================================
//  Channel   Handshake            Payload
//  input     start, busy          req_type .. out_length
//  result    done (one cycle)     status, out_char, new_state, last
//  config    cfg_valid, cfg_ready cfg_index, cfg_data
//
//  Loads, start and halted process items: one result, the cycle after accept.
//  A process item searches the alphabet slot by slot (one comparator, one
//  alphabet read a cycle), then looks up the tables, then emits its output
//  characters; busy stays high until its last result is issued.
//  Reset leaves the machine halted in state 0; tables hold nothing defined.
//  Results cannot be held off; cfg_ready is always high.
module programmable_mealy_machine_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [pmm_pkg::REQ_W-1:0]       req_type,
    input  wire logic [5:0]                      state_index,
    input  wire logic [4:0]                      symbol_index,
    input  wire logic [3:0]                      char_pos,
    input  wire logic [7:0]                      char_value,
    input  wire logic [5:0]                      target_state,
    input  wire logic                            has_transition,
    input  wire logic [3:0]                      out_length,
    output logic                                 done,
    output logic      [pmm_pkg::STATUS_W-1:0]    status,
    output logic      [7:0]                      out_char,
    output logic      [5:0]                      new_state,
    output logic                                 last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import pmm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_LOOKUP = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SYMCNT_W-1:0] num_symbols_reg;
    logic [STATE_W-1:0]  initial_state_reg;
    logic [STATE_W-1:0]  cur_reg, cur_next;
    logic                halted_reg, halted_next;
    logic [CHAR_W-1:0]   cv_reg, cv_next;
    logic [SYM_W-1:0]    idx_reg, idx_next;
    logic [ENTRY_W-1:0]  entry_reg, entry_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    len_reg, len_next;

    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [STATE_W-1:0]  new_state_reg, new_state_next;
    logic                last_reg, last_next;

    logic                accept;
    logic [SYMCNT_W-1:0] search_len;
    logic [SYMCNT_W-1:0] idx_inc;
    logic [LEN_W-1:0]    len_sat;
    pmm_wr_t             wr;
    logic [SYM_W-1:0]    alpha_raddr;
    logic [ENTRY_W+POS_W-1:0] char_raddr;
    logic [CHAR_W-1:0]   alpha_rdata;
    logic [TRANS_W-1:0]  trans_rdata;
    logic [LEN_W-1:0]    len_rdata;
    logic [CHAR_W-1:0]   char_rdata;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_char  = out_char_reg;
    assign new_state = new_state_reg;
    assign last      = last_reg;

    assign search_len = (num_symbols_reg > SYMCNT_W'(MAX_SYMBOLS))
                        ? SYMCNT_W'(MAX_SYMBOLS) : num_symbols_reg;
    assign idx_inc    = SYMCNT_W'(idx_reg) + SYMCNT_W'(1);
    assign len_sat    = (len_rdata > LEN_W'(MAX_OUT_CHARS)) ? LEN_W'(MAX_OUT_CHARS) : len_rdata;

    // Table writes happen at the accept edge straight from the item's fields.
    always_comb
    begin
        wr.alpha_we   = accept && (req_type == REQ_LOAD_SYMBOL);
        wr.alpha_addr = symbol_index;
        wr.alpha_data = char_value;
        wr.trans_we   = accept && (req_type == REQ_LOAD_TRANS);
        wr.len_we     = accept && (req_type == REQ_LOAD_CHAR);
        wr.char_we    = accept && (req_type == REQ_LOAD_CHAR)
                        && (char_pos < POS_W'(MAX_OUT_CHARS));
        wr.entry      = {state_index, symbol_index};
        wr.trans_data = {has_transition, target_state};
        wr.len_data   = (out_length > LEN_W'(MAX_OUT_CHARS)) ? LEN_W'(MAX_OUT_CHARS)
                                                             : out_length;
        wr.char_pos   = char_pos;
        wr.char_data  = char_value;
    end

    // Read addresses run one slot ahead of the cycle that uses the data.
    assign alpha_raddr = (state_reg == S_SEARCH) ? idx_inc[SYM_W-1:0] : '0;
    assign char_raddr  = (state_reg == S_EMIT) ? {entry_reg, pos_reg + POS_W'(1)}
                                               : {entry_reg, POS_W'(0)};

    pmm_tables u_tables (
        .clk         (clk),
        .wr          (wr),
        .alpha_raddr (alpha_raddr),
        .entry_raddr (entry_next),
        .char_raddr  (char_raddr),
        .alpha_rdata (alpha_rdata),
        .trans_rdata (trans_rdata),
        .len_rdata   (len_rdata),
        .char_rdata  (char_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        halted_next    = halted_reg;
        cv_next        = cv_reg;
        idx_next       = idx_reg;
        entry_next     = entry_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_char_next  = out_char_reg;
        new_state_next = new_state_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next      = 1'b1;
                    status_next    = STAT_ACK;
                    out_char_next  = '0;
                    new_state_next = cur_reg;
                    last_next      = 1'b1;
                    if (req_type == REQ_START)
                    begin
                        cur_next       = initial_state_reg;
                        halted_next    = 1'b0;
                        new_state_next = initial_state_reg;
                    end
                    else if (req_type == REQ_PROCESS)
                    begin
                        if (halted_reg)
                        begin
                            status_next = STAT_HALTED;
                        end
                        else if (search_len == '0)
                        begin
                            status_next = STAT_UNKNOWN;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            cv_next    = char_value;
                            idx_next   = '0;
                            state_next = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (alpha_rdata == cv_reg)
                begin
                    entry_next = {cur_reg, idx_reg};
                    state_next = S_LOOKUP;
                end
                else if (idx_inc == search_len)
                begin
                    done_next      = 1'b1;
                    status_next    = STAT_UNKNOWN;
                    out_char_next  = '0;
                    new_state_next = cur_reg;
                    last_next      = 1'b1;
                    halted_next    = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc[SYM_W-1:0];
                end
            end
            S_LOOKUP:
            begin
                done_next     = 1'b1;
                out_char_next = '0;
                last_next     = 1'b1;
                state_next    = S_IDLE;
                if (!trans_rdata[TRANS_W-1])
                begin
                    status_next    = STAT_NO_TRANS;
                    new_state_next = cur_reg;
                    halted_next    = 1'b1;
                end
                else
                begin
                    cur_next       = trans_rdata[STATE_W-1:0];
                    new_state_next = trans_rdata[STATE_W-1:0];
                    if (len_sat == '0)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        // The first character arrives next cycle; nothing is issued yet.
                        done_next  = 1'b0;
                        len_next   = len_sat;
                        pos_next   = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                done_next     = 1'b1;
                status_next   = STAT_CHAR;
                out_char_next = char_rdata;
                last_next     = (pos_reg + POS_W'(1)) == len_reg;
                pos_next      = pos_reg + POS_W'(1);
                if ((pos_reg + POS_W'(1)) == len_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cur_reg           <= '0;
            halted_reg        <= 1'b1;
            done_reg          <= 1'b0;
            num_symbols_reg   <= SYMCNT_W'(2);
            initial_state_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            halted_reg <= halted_next;
            done_reg   <= done_next;
            // The state count is accepted but the datapath has no use for it.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NUM_SYMBOLS)
                begin
                    num_symbols_reg <= cfg_data[SYMCNT_W-1:0];
                end
                else if (cfg_index == CFG_INITIAL_STATE)
                begin
                    initial_state_reg <= cfg_data[STATE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cv_reg        <= cv_next;
        idx_reg       <= idx_next;
        entry_reg     <= entry_next;
        pos_reg       <= pos_next;
        len_reg       <= len_next;
        status_reg    <= status_next;
        out_char_reg  <= out_char_next;
        new_state_reg <= new_state_next;
        last_reg      <= last_next;
    end

endmodule
`default_nettype wire
